@@ sv/edfs_pkg.sv @@
`timescale 1ns / 1ps
package edfs_pkg;

	localparam int DEF_MAX_TASKS = 16;

	// input operation codes
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_TICK   = 2'd1,
		OP_FINISH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// segment close reasons
	typedef enum logic [1:0] {
		RSN_FINISHED = 2'd0,
		RSN_SWITCHED = 2'd1,
		RSN_LOST     = 2'd2,
		RSN_IDLE     = 2'd3
	} reason_t;

	// record kinds
	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// one result record
	typedef struct packed {
		logic        kind;
		logic [3:0]  task_id;
		logic        idle;
		reason_t     reason;
		logic [31:0] duration;
		logic [15:0] arrivals;
		logic [15:0] lost;
		logic        killed;
	} rec_t;

	// sequencer to output buffer
	typedef struct packed {
		logic push;
		logic flush;
	} obuf_ctrl_t;

	// output buffer to sequencer
	typedef struct packed {
		logic can_push;
		logic pend_valid;
		logic out_free;
	} obuf_stat_t;

	// saturating 32-bit add of a 16-bit offset
	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// saturating 32-bit increment
	function automatic logic [31:0] sat_inc32(input logic [31:0] a);
		return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
	endfunction

	// saturating 16-bit increment
	function automatic logic [15:0] sat_inc16(input logic [15:0] a);
		return (a == 16'hFFFF) ? a : a + 16'd1;
	endfunction

endpackage

@@ sv/edfs_outbuf.sv @@
`timescale 1ns / 1ps
module edfs_outbuf (
	input  logic               clk,
	input  logic               arst_n,
	input  edfs_pkg::obuf_ctrl_t ctrl,
	input  edfs_pkg::rec_t     rec,
	output edfs_pkg::obuf_stat_t stat,
	output logic               m_tvalid,
	input  logic               m_tready,
	output edfs_pkg::rec_t     m_rec,
	output logic               m_tlast
);
	import edfs_pkg::*;

	rec_t pend_q;
	logic pend_v_q;
	rec_t out_q;
	logic out_v_q;
	logic out_last_q;
	logic out_free;
	logic can_push;

	// the pending record waits until we know whether it is the last one
	assign out_free = !out_v_q || m_tready;
	assign can_push = !pend_v_q || out_free;

	assign stat.can_push   = can_push;
	assign stat.pend_valid = pend_v_q;
	assign stat.out_free   = out_free;

	assign m_tvalid = out_v_q;
	assign m_rec    = out_q;
	assign m_tlast  = out_last_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			if (ctrl.push && can_push) begin
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end
				pend_v_q <= 1'b1;
			end else if (ctrl.flush && pend_v_q && out_free) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctrl.push && can_push) begin
			if (pend_v_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
			pend_q <= rec;
		end else if (ctrl.flush && pend_v_q && out_free) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

endmodule

@@ sv/edfs_seq.sv @@
`timescale 1ns / 1ps
module edfs_seq #(
	parameter int MAX_TASKS = edfs_pkg::DEF_MAX_TASKS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_data,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [1:0]         op_in,
	input  logic [3:0]         task_index,
	input  logic [15:0]        burst,
	input  logic [15:0]        period,
	input  logic [15:0]        rel_deadline,
	input  logic [15:0]        first_arrival,
	input  logic [15:0]        file_order,
	input  edfs_pkg::obuf_stat_t stat,
	output edfs_pkg::obuf_ctrl_t ctrl,
	output edfs_pkg::rec_t     rec
);
	import edfs_pkg::*;

	localparam int TIDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int N_W    = (CNT_W > 5) ? CNT_W : 5;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PASS  = 7'b0000010,
		ST_DEC1  = 7'b0000100,
		ST_DEC2  = 7'b0001000,
		ST_FIN   = 7'b0010000,
		ST_SUM   = 7'b0100000,
		ST_FLUSH = 7'b1000000
	} state_t;

	state_t state_q;

	// task table
	logic [15:0] burst_q  [MAX_TASKS];
	logic [15:0] period_q [MAX_TASKS];
	logic [15:0] reldl_q  [MAX_TASKS];
	logic [15:0] rank_q   [MAX_TASKS];
	logic [31:0] nrel_q   [MAX_TASKS];
	logic [15:0] rem_q    [MAX_TASKS];
	logic [31:0] absdl_q  [MAX_TASKS];
	logic [15:0] arr_q    [MAX_TASKS];
	logic [15:0] miss_q   [MAX_TASKS];

	logic [4:0]        tcount_q;
	logic [31:0]       now_q;
	logic              run_v_q;
	logic [TIDX_W-1:0] run_idx_q;
	logic [31:0]       seg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  n_q;
	logic              best_v_q;
	logic [TIDX_W-1:0] best_idx_q;
	logic [31:0]       best_dl_q;
	logic [15:0]       best_rank_q;

	logic              acc;
	logic [N_W-1:0]    tc_ext;
	logic [CNT_W-1:0]  n_use;
	logic [TIDX_W-1:0] ix;
	logic              load_ok;
	logic [TIDX_W-1:0] load_ix;

	// shared per-entry unit
	logic        due;
	logic [31:0] dl_new;
	logic [31:0] nrel_new;
	logic [15:0] rem_a;
	logic [31:0] dl_a;
	logic        lost;
	logic [15:0] rem_b;
	logic        cand_better;
	logic        lost_running;
	logic        need_emit;
	logic        stall;
	logic        last_ix;
	logic        same;
	logic [15:0] rem_dec;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign tc_ext   = N_W'(tcount_q);
	assign n_use    = (tc_ext > N_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : CNT_W'(tc_ext);
	assign ix       = cnt_q[TIDX_W-1:0];
	assign load_ok  = (int'(task_index) < MAX_TASKS);
	assign load_ix  = TIDX_W'(task_index);
	assign last_ix  = (cnt_q == n_q - CNT_W'(1));

	// release, loss check and candidate compare for one entry
	always_comb begin
		due      = (nrel_q[ix] == now_q);
		dl_new   = sat_add32(now_q, reldl_q[ix]);
		nrel_new = sat_add32(now_q, period_q[ix]);
		rem_a    = due ? burst_q[ix] : rem_q[ix];
		dl_a     = due ? dl_new : absdl_q[ix];
		lost     = (rem_a != 16'd0) && (dl_a == now_q);
		rem_b    = lost ? 16'd0 : rem_a;
		cand_better = (rem_b != 16'd0) && (!best_v_q || (dl_a < best_dl_q) ||
			((dl_a == best_dl_q) && (rank_q[ix] < best_rank_q)));
		lost_running = lost && run_v_q && (run_idx_q == ix);
		same    = (best_v_q == run_v_q) && (!best_v_q || (best_idx_q == run_idx_q));
		rem_dec = rem_q[ix] - 16'd1;
	end

	// record selection and emit request per state
	always_comb begin
		rec        = '0;
		ctrl       = '0;
		need_emit  = 1'b0;
		unique case (state_q)
			ST_PASS: begin
				need_emit    = lost_running && (seg_q != 32'd0);
				rec.task_id  = 4'(ix);
				rec.reason   = RSN_LOST;
				rec.duration = seg_q;
			end
			ST_DEC1, ST_FIN: begin
				need_emit    = (state_q == ST_FIN || !same) && (seg_q != 32'd0);
				rec.task_id  = run_v_q ? 4'(run_idx_q) : 4'd0;
				rec.idle     = !run_v_q;
				rec.reason   = run_v_q ? RSN_SWITCHED : RSN_IDLE;
				rec.duration = seg_q;
			end
			ST_DEC2: begin
				need_emit    = best_v_q && (rem_dec == 16'd0);
				rec.task_id  = 4'(ix);
				rec.reason   = RSN_FINISHED;
				rec.duration = seg_q;
			end
			ST_SUM: begin
				need_emit    = 1'b1;
				rec.kind     = KIND_SUMMARY;
				rec.task_id  = 4'(ix);
				rec.arrivals = arr_q[ix];
				rec.lost     = miss_q[ix];
				rec.killed   = (rem_q[ix] != 16'd0);
			end
			ST_FLUSH: begin
				ctrl.flush = 1'b1;
			end
			default: begin
			end
		endcase
		ctrl.push = need_emit;
		stall     = need_emit && !stat.can_push;
	end

	// table entries without reset value
	always_ff @(posedge clk) begin
		if (acc && op_t'(op_in) == OP_LOAD && load_ok) begin
			burst_q[load_ix]  <= burst;
			period_q[load_ix] <= period;
			reldl_q[load_ix]  <= rel_deadline;
			rank_q[load_ix]   <= file_order;
			nrel_q[load_ix]   <= {16'd0, first_arrival};
		end else if (state_q == ST_PASS && !stall && due) begin
			nrel_q[ix] <= nrel_new;
		end
	end

	// sequencer, counters and time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tcount_q    <= 5'd0;
			now_q       <= 32'd0;
			run_v_q     <= 1'b0;
			run_idx_q   <= '0;
			seg_q       <= 32'd0;
			cnt_q       <= '0;
			n_q         <= '0;
			best_v_q    <= 1'b0;
			best_idx_q  <= '0;
			best_dl_q   <= 32'd0;
			best_rank_q <= 16'd0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				rem_q[i]   <= 16'd0;
				absdl_q[i] <= 32'd0;
				arr_q[i]   <= 16'd0;
				miss_q[i]  <= 16'd0;
			end
		end else begin
			if (cfg_we) begin
				tcount_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						n_q      <= n_use;
						cnt_q    <= '0;
						best_v_q <= 1'b0;
						case (op_t'(op_in))
							OP_LOAD: begin
								if (load_ok) begin
									rem_q[load_ix]   <= 16'd0;
									absdl_q[load_ix] <= 32'd0;
									arr_q[load_ix]   <= 16'd0;
									miss_q[load_ix]  <= 16'd0;
								end
							end
							OP_TICK: begin
								state_q <= (n_use == '0) ? ST_DEC1 : ST_PASS;
							end
							OP_FINISH: begin
								state_q <= ST_FIN;
							end
							default: begin
							end
						endcase
					end
				end
				// one table entry per cycle unless the output stalls
				ST_PASS: begin
					if (!stall) begin
						rem_q[ix]   <= rem_b;
						absdl_q[ix] <= dl_a;
						if (due) begin
							arr_q[ix] <= sat_inc16(arr_q[ix]);
						end
						if (lost) begin
							miss_q[ix] <= sat_inc16(miss_q[ix]);
						end
						if (lost_running) begin
							run_v_q <= 1'b0;
							seg_q   <= 32'd0;
						end
						if (cand_better) begin
							best_v_q    <= 1'b1;
							best_idx_q  <= ix;
							best_dl_q   <= dl_a;
							best_rank_q <= rank_q[ix];
						end
						cnt_q <= cnt_q + CNT_W'(1);
						if (last_ix) begin
							state_q <= ST_DEC1;
						end
					end
				end
				// switch to the chosen task
				ST_DEC1: begin
					if (!stall) begin
						if (same) begin
							seg_q <= sat_inc32(seg_q);
						end else begin
							run_v_q   <= best_v_q;
							run_idx_q <= best_idx_q;
							seg_q     <= 32'd1;
						end
						cnt_q   <= CNT_W'(best_idx_q);
						state_q <= ST_DEC2;
					end
				end
				// run the chosen task for one tick
				ST_DEC2: begin
					if (!stall) begin
						if (best_v_q) begin
							rem_q[ix] <= rem_dec;
							if (rem_dec == 16'd0) begin
								run_v_q <= 1'b0;
								seg_q   <= 32'd0;
							end
						end
						now_q   <= sat_inc32(now_q);
						state_q <= ST_FLUSH;
					end
				end
				// close the open segment at end of run
				ST_FIN: begin
					if (!stall) begin
						run_v_q <= 1'b0;
						seg_q   <= 32'd0;
						now_q   <= 32'd0;
						cnt_q   <= '0;
						state_q <= (n_q == '0) ? ST_FLUSH : ST_SUM;
					end
				end
				// one summary per entry
				ST_SUM: begin
					if (!stall) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (last_ix) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!stat.pend_valid || stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/edf_periodic_task_scheduler_top.sv @@
`timescale 1ns / 1ps
// channel  | dir | signals                    | contents
// s_*      | in  | tvalid tready tdata tuser  | request: load, tick or finish
// m_*      | out | tvalid tready tdata tuser  | segment or summary record, tlast
// cfg_*    | in  | we data                    | task_count register
//
// a load writes a table entry; a tick passes once over the task table through
// the shared release/compare unit, one entry per cycle, then runs the chosen
// task; a finish emits one summary per entry. s_tready is low while a request
// is in work. result backpressure stalls the pass; one record is held back so
// tlast can be set. arst_n clears control, time, counters and remaining work.
module edf_periodic_task_scheduler_top #(
	parameter int MAX_TASKS = edfs_pkg::DEF_MAX_TASKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// task_index, burst, period, rel_deadline, first_arrival, file_order, zero pad
	input  logic [87:0] s_tdata,
	// operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// task_id, idle, reason, duration, arrivals, lost, killed
	output logic [71:0] m_tdata,
	// kind
	output logic        m_tuser,
	output logic        m_tlast
);
	import edfs_pkg::*;

	obuf_ctrl_t ctrl;
	obuf_stat_t stat;
	rec_t       rec;
	rec_t       m_rec;

	edfs_seq #(
		.MAX_TASKS(MAX_TASKS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.op_in        (s_tuser),
		.task_index   (s_tdata[3:0]),
		.burst        (s_tdata[19:4]),
		.period       (s_tdata[35:20]),
		.rel_deadline (s_tdata[51:36]),
		.first_arrival(s_tdata[67:52]),
		.file_order   (s_tdata[83:68]),
		.stat         (stat),
		.ctrl         (ctrl),
		.rec          (rec)
	);

	edfs_outbuf u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.rec     (rec),
		.stat    (stat),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_rec   (m_rec),
		.m_tlast (m_tlast)
	);

	// pack the record, first field lowest
	assign m_tuser = m_rec.kind;
	assign m_tdata = {m_rec.killed, m_rec.lost, m_rec.arrivals, m_rec.duration,
		m_rec.reason, m_rec.idle, m_rec.task_id};

endmodule
